/* rtl/levelized_event_bucket_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// levelized event bucket queue - assertion macros
// shared check macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LEVELIZED_EVENT_BUCKET_QUEUE_CORE_DEFINES_SVH
`define LEVELIZED_EVENT_BUCKET_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define LEBQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, the consequent may carry a further delay
`define LEBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);

`endif

/* rtl/lebq_pkg.sv */
// ----------------------------------------------------------------------------
// lebq_pkg
// types, op codes and defaults of the levelized event bucket queue
// ----------------------------------------------------------------------------
package lebq_pkg;

  localparam int LEVELS_DEF = 128;
  localparam int NODES_DEF  = 1024;

  // level finder groups the occupancy bitmap in slices of 1 << LVL_GRP_W levels
  localparam int LVL_GRP_W = 4;
  localparam int LVL_GRP   = 1 << LVL_GRP_W;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] node_id;
    logic [6:0] node_level;
  } req_t;

  typedef struct packed {
    logic [9:0] out_node;
    logic       got_node;
    logic       was_duplicate;
  } rsp_t;

endpackage

/* rtl/lebq_lvl_find.sv */
// ----------------------------------------------------------------------------
// lebq_lvl_find
// two-step search for the lowest occupied level: group flags are registered
// on load, the next cycle picks the first group and the first level in it
// ----------------------------------------------------------------------------
module lebq_lvl_find #(
  parameter int LEVELS = lebq_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [LEVELS-1:0]         occ,
  output logic                      any,
  output logic [$clog2(LEVELS)-1:0] lvl
);
  import lebq_pkg::*;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int NGRP   = (LEVELS + LVL_GRP - 1) / LVL_GRP;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NGRP_P = 1 << GRP_W;
  localparam int PAD_W  = NGRP_P * LVL_GRP;

  logic [PAD_W-1:0]         occ_pad;
  logic [NGRP_P-1:0]        grp_any;
  logic [NGRP_P-1:0]        grp_any_r;
  logic [GRP_W-1:0]         first_grp;
  logic [LVL_GRP-1:0]       grp_bits;
  logic [LVL_GRP_W-1:0]     first_bit;
  logic [GRP_W+LVL_GRP_W-1:0] found;

  assign occ_pad = {{(PAD_W-LEVELS){1'b0}}, occ};

  always_comb begin
    for (int g = 0; g < NGRP_P; g++) begin
      grp_any[g] = |occ_pad[g*LVL_GRP +: LVL_GRP];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_any_r <= grp_any;
    end
  end

  // descending walk so the lowest set flag wins
  always_comb begin
    first_grp = '0;
    for (int g = NGRP_P-1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        first_grp = GRP_W'(g);
      end
    end
  end

  assign grp_bits = occ_pad[{first_grp, {LVL_GRP_W{1'b0}}} +: LVL_GRP];

  always_comb begin
    first_bit = '0;
    for (int b = LVL_GRP-1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        first_bit = LVL_GRP_W'(b);
      end
    end
  end

  assign found = {first_grp, first_bit};
  assign any   = |grp_any_r;
  assign lvl   = LVL_W'(found);

endmodule

/* rtl/levelized_event_bucket_queue_core.sv */
// ----------------------------------------------------------------------------
// levelized_event_bucket_queue_core
// per-level lifo buckets linked through a node memory, with duplicate
// suppression and lowest-level-first service
// ----------------------------------------------------------------------------
// channel   ports                      direction  handshake
// input     start, busy, in_req        in         start && !busy
// result    out_valid, out_rsp         out        one-cycle strobe
//
// a put reads the bucket head and node memories and then may write both; a get
// loads the level finder, then reads the bucket head memory and then the
// node memory, and stops after the finder when the queue is empty; a clear
// walks every node memory word; an unused op answers from idle. after reset
// a clearing pass runs over the node memory with busy high. every op returns
// exactly one result; the receiver has no way to stall it.
// ----------------------------------------------------------------------------
`include "levelized_event_bucket_queue_core_defines.svh"

module levelized_event_bucket_queue_core #(
  parameter int LEVELS = lebq_pkg::LEVELS_DEF,
  parameter int NODES  = lebq_pkg::NODES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lebq_pkg::req_t in_req,
  output logic           out_valid,
  output lebq_pkg::rsp_t out_rsp
);
  import lebq_pkg::*;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int NODE_W = $clog2(NODES);
  localparam int NMEM_W = NODE_W + 2;
  localparam int MARK_B = NODE_W + 1;
  localparam int LINK_B = NODE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUT   = 3'd1;
  localparam logic [2:0] ST_GFIND = 3'd2;
  localparam logic [2:0] ST_GHEAD = 3'd3;
  localparam logic [2:0] ST_GLINK = 3'd4;
  localparam logic [2:0] ST_CLR   = 3'd5;

  // node memory word: queued mark, link valid, link node
  logic [NMEM_W-1:0] node_mem [NODES];
  logic [NODE_W-1:0] head_mem [LEVELS];

  logic [2:0]        state_r, state_nxt;
  logic [LEVELS-1:0] head_valid_r, head_valid_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              ok_r, ok_nxt;
  logic [NODE_W-1:0] cnt_r, cnt_nxt;
  logic              clr_rsp_r, clr_rsp_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  logic              node_we, node_re;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  logic [NMEM_W-1:0] node_wdata, node_rdata_r;
  logic              head_we, head_re;
  logic [LVL_W-1:0]  head_waddr, head_raddr;
  logic [NODE_W-1:0] head_wdata, head_rdata_r;

  logic              accept;
  logic              find_load, find_any;
  logic [LVL_W-1:0]  find_lvl;
  logic [NODE_W-1:0] in_node;
  logic [LVL_W-1:0]  in_lvl;
  logic              in_ok;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_node = NODE_W'(in_req.node_id);
  assign in_lvl  = LVL_W'(in_req.node_level);
  assign in_ok   = (32'(in_req.node_id) < NODES) && (32'(in_req.node_level) < LEVELS);

  lebq_lvl_find #(
    .LEVELS (LEVELS)
  ) u_lvl_find (
    .clk  (clk),
    .load (find_load),
    .occ  (head_valid_r),
    .any  (find_any),
    .lvl  (find_lvl)
  );

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata_r <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_r <= head_mem[head_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_valid_nxt = head_valid_r;
    node_nxt       = node_r;
    lvl_nxt        = lvl_r;
    ok_nxt         = ok_r;
    cnt_nxt        = cnt_r;
    clr_rsp_nxt    = clr_rsp_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    node_we        = 1'b0;
    node_waddr     = node_r;
    node_wdata     = '0;
    node_re        = 1'b0;
    node_raddr     = node_r;
    head_we        = 1'b0;
    head_waddr     = lvl_r;
    head_wdata     = node_r;
    head_re        = 1'b0;
    head_raddr     = lvl_r;
    find_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req.op)
            OP_PUT: begin
              node_nxt   = in_node;
              lvl_nxt    = in_lvl;
              ok_nxt     = in_ok;
              head_re    = 1'b1;
              head_raddr = in_lvl;
              node_re    = 1'b1;
              node_raddr = in_node;
              state_nxt  = ST_PUT;
            end
            OP_GET: begin
              find_load = 1'b1;
              state_nxt = ST_GFIND;
            end
            OP_CLR: begin
              head_valid_nxt = '0;
              cnt_nxt        = '0;
              clr_rsp_nxt    = 1'b1;
              state_nxt      = ST_CLR;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
            end
          endcase
        end
      end
      ST_PUT: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '0;
        if (ok_r) begin
          if (node_rdata_r[MARK_B]) begin
            out_rsp_nxt.was_duplicate = 1'b1;
          end else begin
            // new head links to the old one
            node_we               = 1'b1;
            node_wdata            = {1'b1, head_valid_r[lvl_r], head_rdata_r};
            head_we               = 1'b1;
            head_valid_nxt[lvl_r] = 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_GFIND: begin
        if (find_any) begin
          lvl_nxt    = find_lvl;
          head_re    = 1'b1;
          head_raddr = find_lvl;
          state_nxt  = ST_GHEAD;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_GHEAD: begin
        node_re    = 1'b1;
        node_raddr = head_rdata_r;
        node_nxt   = head_rdata_r;
        state_nxt  = ST_GLINK;
      end
      ST_GLINK: begin
        // pop: drop the mark, the link becomes the bucket head
        node_we               = 1'b1;
        node_wdata            = {1'b0, node_rdata_r[LINK_B:0]};
        head_we               = 1'b1;
        head_wdata            = node_rdata_r[NODE_W-1:0];
        head_valid_nxt[lvl_r] = node_rdata_r[LINK_B];
        out_valid_nxt         = 1'b1;
        out_rsp_nxt           = '{out_node: 10'(node_r), got_node: 1'b1,
                                  was_duplicate: 1'b0};
        state_nxt             = ST_IDLE;
      end
      ST_CLR: begin
        node_we    = 1'b1;
        node_waddr = cnt_r;
        node_wdata = '0;
        if (cnt_r == NODE_W'(NODES - 1)) begin
          if (clr_rsp_r) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end
          clr_rsp_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      head_valid_r <= '0;
      cnt_r        <= '0;
      clr_rsp_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_valid_r <= head_valid_nxt;
      cnt_r        <= cnt_nxt;
      clr_rsp_r    <= clr_rsp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    lvl_r     <= lvl_nxt;
    ok_r      <= ok_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  `LEBQ_ASSERT_NEXT(a_put_rsp, accept && (in_req.op == OP_PUT), ##1 out_valid_r, "put without result two cycles later")
  `LEBQ_ASSERT_NOW(a_pop_occupied, state_r == ST_GLINK, head_valid_r[lvl_r], "pop from an empty bucket")
  `LEBQ_ASSERT_NEXT(a_clr_empty, accept && (in_req.op == OP_CLR), (head_valid_r == '0), "buckets not emptied by clear")

endmodule
